// File: design/ifmt_pkg.sv
// ============================================================================
// ifmt_pkg
// Shared types, codes and character helpers for the integer field formatter.
// ============================================================================
package ifmt_pkg;

    // default field limit, handed down as the top-level parameter default
    localparam int MAX_FIELD_DEF = 63;

    // request field widths
    localparam int VAL_W    = 64;
    localparam int FW_W     = 6;
    localparam int PREC_W   = 7;
    localparam int PSAT_W   = 6;
    localparam int SHORT_W  = 16;
    localparam int INT_W    = 32;

    // digit store: 22 lanes cover 64-bit octal, decimal and hex
    localparam int NDIG     = 22;
    localparam int DIGIT_W  = 4;
    localparam int DIG_AW   = $clog2(NDIG);
    localparam int NDIG_W   = $clog2(NDIG + 1);
    localparam int CNT_W    = $clog2(VAL_W);

    // conversion codes
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_LHEX = 3'd3;
    localparam logic [2:0] MODE_UHEX = 3'd4;

    // argument size codes
    localparam logic [1:0] SIZE_INT   = 2'd0;
    localparam logic [1:0] SIZE_SHORT = 2'd1;
    localparam logic [1:0] SIZE_LONG  = 2'd2;

    // characters
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_A_UP  = 8'h41;
    localparam logic [7:0] ASCII_A_LO  = 8'h61;
    localparam logic [7:0] ASCII_X_UP  = 8'h58;
    localparam logic [7:0] ASCII_X_LO  = 8'h78;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    // layout controls held for the length of one request
    typedef struct packed {
        logic              has_sign;
        logic [7:0]        sign_ch;
        logic [1:0]        npfx;
        logic              upper;
        logic              left;
        logic              zpad;
        logic [FW_W-1:0]   width;
        logic [PSAT_W-1:0] prec;
    } fmt_req_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d,
                                              input logic upper);
        logic [7:0] ch;
        if (d < DIGIT_W'(10))
            ch = ASCII_0 + 8'(d);
        else if (upper)
            ch = ASCII_A_UP + 8'(d) - 8'd10;
        else
            ch = ASCII_A_LO + 8'(d) - 8'd10;
        return ch;
    endfunction

endpackage

// File: design/ifmt_digits.sv
// ============================================================================
// ifmt_digits
// Digit unit: splits a magnitude into decimal, octal or hex digits and
// finds the digit count.
// ============================================================================
module ifmt_digits
    import ifmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [VAL_W-1:0]    mag,
    input  base_t               base,
    input  logic [DIG_AW-1:0]   rd_addr,
    output logic [DIGIT_W-1:0]  rd_digit,
    output logic                done,
    output logic [NDIG_W-1:0]   ndig
);

    typedef enum logic [2:0] {
        D_IDLE   = 3'b001,
        D_DABBLE = 3'b010,
        D_SCAN   = 3'b100
    } dstate_t;

    dstate_t              state_reg, state_next;
    logic [DIGIT_W-1:0]   dig_reg [NDIG];
    logic [DIGIT_W-1:0]   dig_next [NDIG];
    logic [DIGIT_W-1:0]   adj [NDIG];
    logic [DIGIT_W-1:0]   loaded [NDIG];
    logic [VAL_W-1:0]     sh_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIG_AW-1:0]    idx_reg;
    logic                 done_reg;
    logic [NDIG_W-1:0]    ndig_reg;
    logic [DIG_AW-1:0]    rd_idx;
    logic [NDIG*4-1:0]    mag_hex;
    logic [NDIG*3-1:0]    mag_oct;
    logic                 scan_hit;

    assign mag_hex = (NDIG*4)'(mag);
    assign mag_oct = (NDIG*3)'(mag);

    // shift-and-add-3 step over all bcd lanes, and direct split for oct/hex
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[i] = (dig_reg[i] >= DIGIT_W'(5)) ? dig_reg[i] + DIGIT_W'(3) : dig_reg[i];
            if (base == BASE_HEX)
                loaded[i] = mag_hex[4*i +: 4];
            else
                loaded[i] = {1'b0, mag_oct[3*i +: 3]};
        end
        dig_next[0] = {adj[0][2:0], sh_reg[VAL_W-1]};
        for (int i = 1; i < NDIG; i++)
            dig_next[i] = {adj[i][2:0], adj[i-1][3]};
    end

    // single read port, shared by the count scan and the emitter
    assign rd_idx   = (state_reg == D_SCAN) ? idx_reg : rd_addr;
    assign rd_digit = (rd_idx < DIG_AW'(NDIG)) ? dig_reg[rd_idx] : '0;
    assign scan_hit = (rd_digit != '0) || (idx_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                    state_next = (base == BASE_DEC) ? D_DABBLE : D_SCAN;
            end
            D_DABBLE:
            begin
                if (cnt_reg == CNT_W'(VAL_W - 1))
                    state_next = D_SCAN;
            end
            D_SCAN:
            begin
                if (scan_hit)
                    state_next = D_IDLE;
            end
            default:
                state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == D_IDLE && start)
            begin
                cnt_reg <= '0;
                idx_reg <= DIG_AW'(NDIG - 1);
            end
            else if (state_reg == D_DABBLE)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (state_reg == D_SCAN)
            begin
                if (scan_hit)
                begin
                    ndig_reg <= NDIG_W'(idx_reg) + NDIG_W'(1);
                    done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg - DIG_AW'(1);
                end
            end
        end
    end

    // digit lanes and shift source
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            sh_reg <= mag;
            for (int i = 0; i < NDIG; i++)
                dig_reg[i] <= (base == BASE_DEC) ? '0 : loaded[i];
        end
        else if (state_reg == D_DABBLE)
        begin
            sh_reg <= {sh_reg[VAL_W-2:0], 1'b0};
            for (int i = 0; i < NDIG; i++)
                dig_reg[i] <= dig_next[i];
        end
    end

    assign done = done_reg;
    assign ndig = ndig_reg;

endmodule

// File: design/ifmt_emit.sv
// ============================================================================
// ifmt_emit
// Emitter: works out the field layout and sends one character per cycle.
// ============================================================================
module ifmt_emit
    import ifmt_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fmt_req_t            req,
    input  logic [NDIG_W-1:0]   ndig,
    input  logic [DIGIT_W-1:0]  rd_digit,
    output logic [DIG_AW-1:0]   rd_addr,
    output logic                strobe,
    output logic [7:0]          char_out,
    output logic                last,
    output logic                done
);

    localparam int BW = $clog2(MAX_FIELD + 26);

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_PLAN1 = 5'b00010,
        E_PLAN2 = 5'b00100,
        E_PLAN3 = 5'b01000,
        E_RUN   = 5'b10000
    } estate_t;

    estate_t        state_reg, state_next;
    logic [BW-1:0]  body_reg, precz_reg, pad_reg, total_reg;
    logic [BW-1:0]  b1_reg, b2_reg, b3_reg, b5_reg, b6_reg;
    logic [BW-1:0]  k_reg;
    logic           strobe_reg, last_reg;
    logic [7:0]     char_reg;

    logic [BW-1:0]  prec_e, ndig_e, width_e, sign_e, npfx_e;
    logic [BW-1:0]  maxpd, wide, lead, zp, dig_off;
    logic [BW-1:0]  b2_c, b3_c, b4_c, b5_c;
    logic           is_last;
    logic [7:0]     ch;

    assign prec_e  = BW'(req.prec);
    assign ndig_e  = BW'(ndig);
    assign width_e = BW'(req.width);
    assign sign_e  = BW'(req.has_sign);
    assign npfx_e  = BW'(req.npfx);

    assign maxpd = (prec_e > ndig_e) ? prec_e : ndig_e;
    assign wide  = (width_e > body_reg) ? width_e : body_reg;
    assign lead  = (!req.left && !req.zpad) ? pad_reg : '0;
    assign zp    = (!req.left &&  req.zpad) ? pad_reg : '0;
    assign b2_c  = lead + sign_e;
    assign b3_c  = b2_c + npfx_e;
    assign b4_c  = b3_c + zp;
    assign b5_c  = b4_c + precz_reg;

    // digits go out most significant first
    assign dig_off = b6_reg - k_reg - BW'(1);
    assign rd_addr = dig_off[DIG_AW-1:0];
    assign is_last = (k_reg == total_reg - BW'(1));

    always_comb
    begin
        if (k_reg < b1_reg)
            ch = ASCII_SPACE;
        else if (k_reg < b2_reg)
            ch = req.sign_ch;
        else if (k_reg < b3_reg)
            ch = (k_reg == b2_reg) ? ASCII_0 : (req.upper ? ASCII_X_UP : ASCII_X_LO);
        else if (k_reg < b5_reg)
            ch = ASCII_0;
        else if (k_reg < b6_reg)
            ch = digit_char(rd_digit, req.upper);
        else
            ch = ASCII_SPACE;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:  if (start) state_next = E_PLAN1;
            E_PLAN1: state_next = E_PLAN2;
            E_PLAN2: state_next = E_PLAN3;
            E_PLAN3: state_next = E_RUN;
            E_RUN:   if (is_last) state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            k_reg      <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == E_RUN);
            last_reg   <= (state_reg == E_RUN) && is_last;
            if (state_reg == E_PLAN3)
                k_reg <= '0;
            else if (state_reg == E_RUN)
                k_reg <= k_reg + BW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == E_PLAN1)
        begin
            precz_reg <= (prec_e > ndig_e) ? prec_e - ndig_e : '0;
            body_reg  <= sign_e + npfx_e + maxpd;
        end
        if (state_reg == E_PLAN2)
        begin
            pad_reg   <= (width_e > body_reg) ? width_e - body_reg : '0;
            total_reg <= (wide > BW'(MAX_FIELD)) ? BW'(MAX_FIELD) : wide;
        end
        if (state_reg == E_PLAN3)
        begin
            b1_reg <= lead;
            b2_reg <= b2_c;
            b3_reg <= b3_c;
            b5_reg <= b5_c;
            b6_reg <= b5_c + ndig_e;
        end
        if (state_reg == E_RUN)
            char_reg <= ch;
    end

    assign strobe   = strobe_reg;
    assign char_out = char_reg;
    assign last     = last_reg;
    assign done     = (state_reg == E_RUN) && is_last;

endmodule

// File: design/integer_field_formatter.sv
// ============================================================================
// integer_field_formatter
// Formats one integer conversion request into ASCII characters, one per
// cycle, with the final character marked.
// ============================================================================
// A request is taken when start is high and busy is low; busy then stays
// high until the last character of the field has been sent. Characters come
// out on char_out for exactly one cycle each, marked by strobe, with last
// set on the final one; the receiver cannot stall them and must take one per
// cycle. An accepted request goes to the digit unit: decimal runs 64
// shift-and-add-3 steps with an add-3 adjust on every bcd lane, while octal
// and hex split the value straight into the lanes. A top-down scan of the
// 22-entry digit store then finds the digit count, the planning states
// PLAN1, PLAN2 and PLAN3 work out the layout, and the characters follow at
// one per cycle. A request with an unknown mode produces no characters and
// leaves busy low.
// ============================================================================
module integer_field_formatter
    import ifmt_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               mode,
    input  logic [VAL_W-1:0]         value,
    input  logic [1:0]               size_mode,
    input  logic                     left_justify,
    input  logic                     plus_sign,
    input  logic                     space_sign,
    input  logic                     zero_pad,
    input  logic                     alternate,
    input  logic [FW_W-1:0]          field_width,
    input  logic signed [PREC_W-1:0] precision,
    output logic                     strobe,
    output logic [7:0]               char_out,
    output logic                     last
);

    // widest width the field can use
    localparam int WMAX = (MAX_FIELD < 63) ? MAX_FIELD : 63;
    localparam int PMAX = MAX_FIELD - 3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    fmt_req_t            req_reg, req_next;

    // request decode
    logic                mode_ok, sdec_conv, neg;
    base_t               base;
    logic [VAL_W-1:0]    sext, zext, mag;
    logic                accept, dig_start;

    // unit handshakes
    logic                dig_done, emit_start, emit_done;
    logic [NDIG_W-1:0]   ndig;
    logic [DIGIT_W-1:0]  rd_digit;
    logic [DIG_AW-1:0]   rd_addr;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign dig_start = accept && mode_ok;

    // cut the argument to its size, both ways
    always_comb
    begin
        unique case (size_mode)
            SIZE_SHORT:
            begin
                sext = {{(VAL_W-SHORT_W){value[SHORT_W-1]}}, value[SHORT_W-1:0]};
                zext = {{(VAL_W-SHORT_W){1'b0}}, value[SHORT_W-1:0]};
            end
            SIZE_LONG:
            begin
                sext = value;
                zext = value;
            end
            default:
            begin
                sext = {{(VAL_W-INT_W){value[INT_W-1]}}, value[INT_W-1:0]};
                zext = {{(VAL_W-INT_W){1'b0}}, value[INT_W-1:0]};
            end
        endcase
    end

    // conversion decode
    always_comb
    begin
        mode_ok   = 1'b1;
        sdec_conv = 1'b0;
        base      = BASE_DEC;
        req_next  = req_reg;
        req_next.upper = 1'b0;
        unique case (mode)
            MODE_SDEC: sdec_conv = 1'b1;
            MODE_UDEC: base = BASE_DEC;
            MODE_OCT:  base = BASE_OCT;
            MODE_LHEX: base = BASE_HEX;
            MODE_UHEX:
            begin
                base = BASE_HEX;
                req_next.upper = 1'b1;
            end
            default:   mode_ok = 1'b0;
        endcase

        // signed decimal prints the magnitude; most negative value included
        neg = sdec_conv && sext[VAL_W-1];
        if (!sdec_conv)
            mag = zext;
        else if (neg)
            mag = ~sext + VAL_W'(1);
        else
            mag = sext;

        req_next.has_sign = sdec_conv && (neg || plus_sign || space_sign);
        req_next.sign_ch  = neg ? ASCII_MINUS : (plus_sign ? ASCII_PLUS : ASCII_SPACE);

        // alternate prefix only for nonzero octal or hex
        if (alternate && (zext != '0) && base == BASE_HEX)
            req_next.npfx = 2'd2;
        else if (alternate && (zext != '0) && base == BASE_OCT)
            req_next.npfx = 2'd1;
        else
            req_next.npfx = 2'd0;

        req_next.left  = left_justify;
        req_next.zpad  = zero_pad;
        req_next.width = ({1'b0, field_width} > (FW_W+1)'(WMAX)) ? FW_W'(WMAX)
                                                                 : field_width;
        // negative precision acts like none at all
        if (precision[PREC_W-1])
            req_next.prec = '0;
        else if ({1'b0, precision[PSAT_W-1:0]} > (PSAT_W+1)'(PMAX))
            req_next.prec = PSAT_W'(PMAX);
        else
            req_next.prec = precision[PSAT_W-1:0];
    end

    // request sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (dig_start) state_next = S_CONV;
            S_CONV: if (dig_done)  state_next = S_EMIT;
            S_EMIT: if (emit_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign emit_start = (state_reg == S_CONV) && dig_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // layout controls stay put for the whole request
    always_ff @(posedge clk)
    begin
        if (dig_start)
            req_reg <= req_next;
    end

    ifmt_digits u_digits (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dig_start),
        .mag      (mag),
        .base     (base),
        .rd_addr  (rd_addr),
        .rd_digit (rd_digit),
        .done     (dig_done),
        .ndig     (ndig)
    );

    ifmt_emit #(
        .MAX_FIELD (MAX_FIELD)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (emit_start),
        .req      (req_reg),
        .ndig     (ndig),
        .rd_digit (rd_digit),
        .rd_addr  (rd_addr),
        .strobe   (strobe),
        .char_out (char_out),
        .last     (last),
        .done     (emit_done)
    );

    // a marked final character only rides on a strobe
    ap_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // characters only follow a cycle of work on a request
    ap_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character sent while idle");

    // the final character frees the block for the next request
    ap_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("still busy after last character");

    // a valid request holds the block busy
    ap_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dig_start |=> busy)
        else $error("request taken but not busy");

    // the digit unit only finishes while a conversion is pending
    ap_done_conv: assert property (@(posedge clk) disable iff (!rst_n)
        dig_done |-> (state_reg == S_CONV))
        else $error("digit unit done outside conversion");

endmodule

// File: tb/sv/integer_field_formatter_check.sv
// ============================================================================
// integer_field_formatter_check
// Watches the request and character channels of the integer field formatter,
// works out the characters each accepted request must produce and compares
// every strobed character and last flag against them in order.
// ============================================================================
`timescale 1ns / 1ps

module integer_field_formatter_check
    import ifmt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [2:0]               mode,
    input  logic [VAL_W-1:0]         value,
    input  logic [1:0]               size_mode,
    input  logic                     left_justify,
    input  logic                     plus_sign,
    input  logic                     space_sign,
    input  logic                     zero_pad,
    input  logic                     alternate,
    input  logic [FW_W-1:0]          field_width,
    input  logic signed [PREC_W-1:0] precision,
    input  logic                     strobe,
    input  logic [7:0]               char_out,
    input  logic                     last,
    output int                       fail_count,
    output int                       chars_due
);

    localparam int FIELD_CAP = MAX_FIELD_DEF;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } field_char_t;

    field_char_t pending_chars[$];

    // builds the whole field for one request and queues its characters
    function automatic void format_field(
        input logic [2:0]               m,
        input logic [VAL_W-1:0]         v,
        input logic [1:0]               sz,
        input logic                     lj,
        input logic                     ps,
        input logic                     ss,
        input logic                     zp,
        input logic                     alt,
        input logic [FW_W-1:0]          fw,
        input logic signed [PREC_W-1:0] pr
    );
        int          wid;
        int          prc;
        int          npfx;
        int          precz;
        int          body;
        int          pad;
        int          n;
        logic        neg;
        logic        has_sign;
        logic        upper;
        logic [7:0]  sign_ch;
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] t;
        logic [3:0]  d;
        logic [3:0]  digs[$];
        logic [7:0]  txt[$];
        field_char_t fc;

        if (m > MODE_UHEX)
            return;

        wid = int'(fw);
        if (wid > FIELD_CAP)
            wid = FIELD_CAP;
        prc = -1;
        if (!pr[PREC_W-1])
        begin
            prc = int'(pr);
            if (prc > FIELD_CAP - 3)
                prc = FIELD_CAP - 3;
        end

        neg = 1'b0;
        has_sign = 1'b0;
        sign_ch = ASCII_SPACE;
        radix = 64'd10;
        upper = (m == MODE_UHEX);

        if (m == MODE_SDEC)
        begin
            // sign extension happens through the magnitude
            if (sz == SIZE_SHORT)
            begin
                neg = v[15];
                mag = neg ? (64'h1_0000 - {48'b0, v[15:0]}) : {48'b0, v[15:0]};
            end
            else if (sz == SIZE_LONG)
            begin
                neg = v[63];
                mag = neg ? (64'd0 - v) : v;
            end
            else
            begin
                neg = v[31];
                mag = neg ? (64'h1_0000_0000 - {32'b0, v[31:0]}) : {32'b0, v[31:0]};
            end
            if (neg)
            begin
                has_sign = 1'b1;
                sign_ch = ASCII_MINUS;
            end
            else if (ps)
            begin
                has_sign = 1'b1;
                sign_ch = ASCII_PLUS;
            end
            else if (ss)
            begin
                has_sign = 1'b1;
                sign_ch = ASCII_SPACE;
            end
        end
        else
        begin
            if (sz == SIZE_SHORT)
                mag = {48'b0, v[15:0]};
            else if (sz == SIZE_LONG)
                mag = v;
            else
                mag = {32'b0, v[31:0]};
            if (m == MODE_OCT)
                radix = 64'd8;
            else if (m != MODE_UDEC)
                radix = 64'd16;
        end

        // digits, least significant first; zero still gives one digit
        t = mag;
        do
        begin
            digs.push_back(4'(t % radix));
            t = t / radix;
        end
        while (t != 64'd0);

        npfx = 0;
        if (alt && mag != 64'd0)
        begin
            if (radix == 64'd16)
                npfx = 2;
            else if (radix == 64'd8)
                npfx = 1;
        end
        precz = (prc > digs.size()) ? prc - digs.size() : 0;
        body = (has_sign ? 1 : 0) + npfx + precz + digs.size();
        pad = (wid > body) ? wid - body : 0;

        if (!lj && !zp)
            repeat (pad) txt.push_back(ASCII_SPACE);
        if (has_sign)
            txt.push_back(sign_ch);
        if (npfx >= 1)
            txt.push_back(ASCII_0);
        if (npfx == 2)
            txt.push_back(upper ? ASCII_X_UP : ASCII_X_LO);
        if (!lj && zp)
            repeat (pad) txt.push_back(ASCII_0);
        repeat (precz) txt.push_back(ASCII_0);
        for (int i = digs.size() - 1; i >= 0; i--)
        begin
            d = digs[i];
            if (d < 4'd10)
                txt.push_back(ASCII_0 + 8'(d));
            else
                txt.push_back((upper ? ASCII_A_UP : ASCII_A_LO) + 8'(d) - 8'd10);
        end
        if (lj)
            repeat (pad) txt.push_back(ASCII_SPACE);

        // the field never grows past the cap; last marks the final kept one
        n = (txt.size() > FIELD_CAP) ? FIELD_CAP : txt.size();
        for (int i = 0; i < n; i++)
        begin
            fc.ch = txt[i];
            fc.fin = (i == n - 1);
            pending_chars.push_back(fc);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        field_char_t want;
        int          errs;
        if (!rst_n)
        begin
            pending_chars.delete();
            fail_count <= 0;
            chars_due <= 0;
        end
        else
        begin
            errs = 0;
            if (strobe)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("char_out: no character expected, got 0x%02h last %0b",
                           char_out, last);
                    errs++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (char_out !== want.ch)
                    begin
                        $error("char_out: expected 0x%02h, actual 0x%02h",
                               want.ch, char_out);
                        errs++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %0b, actual %0b", want.fin, last);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                format_field(mode, value, size_mode, left_justify, plus_sign,
                             space_sign, zero_pad, alternate, field_width, precision);
            fail_count <= fail_count + errs;
            chars_due <= pending_chars.size();
        end
    end

endmodule

// File: tb/sv/integer_field_formatter_tb.sv
// ============================================================================
// integer_field_formatter_tb
// Drives directed and random integer conversion requests into the formatter
// in bursts with random gaps, lets the checker compare every character, and
// gives the verdict once all characters have come out.
// ============================================================================
`timescale 1ns / 1ps

module integer_field_formatter_tb
    import ifmt_pkg::*;
();

    // idle cycles allowed with no request taken and no character out;
    // time a request spends in the digit unit counts as idle
    localparam int WATCHDOG_LIMIT = 4000;
    // drain time after the last expected character
    localparam int TAIL_CYCLES    = 200;
    // random requests that produce characters
    localparam int RANDOM_COUNT   = 250;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               mode;
    logic [VAL_W-1:0]         value;
    logic [1:0]               size_mode;
    logic                     left_justify;
    logic                     plus_sign;
    logic                     space_sign;
    logic                     zero_pad;
    logic                     alternate;
    logic [FW_W-1:0]          field_width;
    logic signed [PREC_W-1:0] precision;
    logic                     strobe;
    logic [7:0]               char_out;
    logic                     last;

    int fail_count;
    int chars_due;
    int idle_cycles = 0;

    integer_field_formatter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .size_mode    (size_mode),
        .left_justify (left_justify),
        .plus_sign    (plus_sign),
        .space_sign   (space_sign),
        .zero_pad     (zero_pad),
        .alternate    (alternate),
        .field_width  (field_width),
        .precision    (precision),
        .strobe       (strobe),
        .char_out     (char_out),
        .last         (last)
    );

    integer_field_formatter_check fmt_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .size_mode    (size_mode),
        .left_justify (left_justify),
        .plus_sign    (plus_sign),
        .space_sign   (space_sign),
        .zero_pad     (zero_pad),
        .alternate    (alternate),
        .field_width  (field_width),
        .precision    (precision),
        .strobe       (strobe),
        .char_out     (char_out),
        .last         (last),
        .fail_count   (fail_count),
        .chars_due    (chars_due)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: any request taken or character out restarts the count
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // put one request on the port and hold it until the formatter takes it;
    // returns in the step of the accepting edge, start still high
    task automatic send_request(
        input logic [2:0]               m,
        input logic [VAL_W-1:0]         v,
        input logic [1:0]               sz,
        input logic                     lj,
        input logic                     ps,
        input logic                     ss,
        input logic                     zp,
        input logic                     alt,
        input logic [FW_W-1:0]          fw,
        input logic signed [PREC_W-1:0] pr
    );
        start        <= 1'b1;
        mode         <= m;
        value        <= v;
        size_mode    <= sz;
        left_justify <= lj;
        plus_sign    <= ps;
        space_sign   <= ss;
        zero_pad     <= zp;
        alternate    <= alt;
        field_width  <= fw;
        precision    <= pr;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every queued character has come out
    task automatic wait_drained();
        do
            @(posedge clk);
        while (chars_due != 0 || busy);
    endtask

    // random request shaped toward the interesting corners; returns 1 when
    // the conversion code is a real one and characters will follow
    task automatic send_random(output bit productive);
        logic [2:0]               m;
        logic [VAL_W-1:0]         v;
        logic signed [PREC_W-1:0] pr;
        logic [FW_W-1:0]          fw;
        int                       b;

        // mostly real conversions, a few unknown codes as noise
        if ($urandom_range(0, 9) == 0)
            m = 3'($urandom_range(5, 7));
        else
            m = 3'($urandom_range(int'(MODE_SDEC), int'(MODE_UHEX)));

        case ($urandom_range(0, 6))
            0, 1, 2: v = {$urandom, $urandom};
            3:       v = 64'($urandom_range(0, 300));
            4:       v = $urandom_range(0, 1) ? '1 : '0;
            5:       v = 64'd1 << $urandom_range(0, 63);
            default:
            begin
                // around the sign bit of each argument size
                case ($urandom_range(0, 2))
                    0:       b = 15;
                    1:       b = 31;
                    default: b = 63;
                endcase
                v = (64'd1 << b) - 64'd2 + 64'($urandom_range(0, 4));
            end
        endcase

        // most fields narrow, some out to the full width
        if ($urandom_range(0, 9) < 7)
            fw = 6'($urandom_range(0, 24));
        else
            fw = 6'($urandom_range(0, 63));

        case ($urandom_range(0, 4))
            0, 1:    pr = -7'sd1;
            2:       pr = 7'($urandom);
            default: pr = 7'($urandom_range(0, 25));
        endcase

        send_request(m, v, 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), fw, pr);
        productive = (m <= MODE_UHEX);
    endtask

    initial
    begin
        int  sent;
        int  burst;
        int  gap;
        bit  productive;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        mode         <= MODE_SDEC;
        value        <= '0;
        size_mode    <= SIZE_INT;
        left_justify <= 1'b0;
        plus_sign    <= 1'b0;
        space_sign   <= 1'b0;
        zero_pad     <= 1'b0;
        alternate    <= 1'b0;
        field_width  <= '0;
        precision    <= -7'sd1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, back to back
        // zero with no flags
        send_request(MODE_SDEC, 64'd0, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                     6'd0, -7'sd1);
        // most negative value of each size
        send_request(MODE_SDEC, 64'h8000_0000, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                     6'd0, -7'sd1);
        send_request(MODE_SDEC, 64'h8000_0000_0000_0000, SIZE_LONG, 1'b0, 1'b1, 1'b0,
                     1'b0, 1'b0, 6'd0, -7'sd1);
        send_request(MODE_SDEC, 64'hFFFF_FFFF_FFFF_8000, SIZE_SHORT, 1'b0, 1'b0, 1'b1,
                     1'b0, 1'b0, 6'd8, -7'sd1);
        // minus one, with plus asked for
        send_request(MODE_SDEC, '1, SIZE_LONG, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                     6'd0, -7'sd1);
        // plus sign with zero fill, space sign left justified
        send_request(MODE_SDEC, 64'd42, SIZE_INT, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                     6'd10, -7'sd1);
        send_request(MODE_SDEC, 64'd42, SIZE_INT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                     6'd10, -7'sd1);
        // plus beats space
        send_request(MODE_SDEC, 64'd7, SIZE_INT, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                     6'd0, -7'sd1);
        // sign flags ignored on unsigned, widest decimal
        send_request(MODE_UDEC, '1, SIZE_LONG, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                     6'd0, -7'sd1);
        // octal prefix on top of precision zeros
        send_request(MODE_OCT, '1, SIZE_LONG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     6'd0, 7'sd30);
        send_request(MODE_OCT, 64'd8, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     6'd0, 7'sd5);
        // hex prefix with zero fill after it
        send_request(MODE_LHEX, 64'hDEAD_BEEF, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                     6'd20, -7'sd1);
        // full width and saturated precision
        send_request(MODE_UHEX, '1, SIZE_LONG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     6'd63, 7'sd60);
        send_request(MODE_UDEC, 64'd12345, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                     6'd63, 7'sd63);
        // zero value: one digit even at precision 0, and no prefix
        send_request(MODE_UHEX, 64'd0, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     6'd0, 7'sd0);
        send_request(MODE_OCT, 64'd0, SIZE_LONG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     6'd4, -7'sd1);
        // unknown conversion codes give nothing
        send_request(3'd5, 64'd99, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                     6'd5, -7'sd1);
        send_request(3'd6, '1, SIZE_LONG, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                     6'd63, 7'sd60);
        send_request(3'd7, 64'd1, SIZE_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                     6'd0, 7'sd0);
        // unknown size code behaves as 32 bit
        send_request(MODE_SDEC, 64'h1234_5678_FFFF_FFFF, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0,
                     1'b0, 6'd0, -7'sd1);
        // left justify wins over zero fill
        send_request(MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFF6, SIZE_LONG, 1'b1, 1'b0, 1'b0,
                     1'b1, 1'b0, 6'd12, -7'sd1);
        // short truncation on hex
        send_request(MODE_LHEX, 64'h1234_5678, SIZE_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     6'd0, -7'sd1);
        // most negative precision code means not given
        send_request(MODE_UDEC, 64'd5, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                     6'd8, 7'sh40);
        // zero fill together with precision
        send_request(MODE_UDEC, 64'd5, SIZE_INT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                     6'd8, 7'sd3);
        start <= 1'b0;

        // sender holds off until the formatter has emptied
        wait_drained();

        // random requests in bursts
        sent = 0;
        while (sent < RANDOM_COUNT)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                send_random(productive);
                if (productive)
                    sent++;
            end
            // gap-free stretches now and then
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                if ($urandom_range(0, 11) == 0)
                    wait_drained();
                else
                    repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && chars_due == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
